// ----- hw/rtl/els_pkg.sv -----
// ----------------------------------------------------------------------------
// els_pkg: event latency statistics shared definitions
// Field widths, function codes, statistic indexes and the control/status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package els_pkg;

   localparam int COUNTER_WIDTH_DEF = 48;
   localparam int LATENCY_WIDTH_DEF = 24;

   localparam int FUNC_W    = 3;
   localparam int BYTE_W    = 32;
   localparam int LAT_IN_W  = 24;
   localparam int IDX_W     = 5;
   localparam int STAT_W    = 48;
   localparam int SAMPLE_W  = 32;
   localparam int SNAP_ID_W = 32;
   localparam int NUM_SRC   = 3;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_COLLECTOR = 3'd0,
      FUNC_ROUTER    = 3'd1,
      FUNC_VIEWER    = 3'd2,
      FUNC_SNAPSHOT  = 3'd3,
      FUNC_CLEAR     = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      SRC_COLLECTOR = 2'd0,
      SRC_ROUTER    = 2'd1,
      SRC_VIEWER    = 2'd2
   } src_type;

   localparam logic [IDX_W-1:0] IDX_COLL_EVENTS = 5'd0;
   localparam logic [IDX_W-1:0] IDX_COLL_OK     = 5'd1;
   localparam logic [IDX_W-1:0] IDX_COLL_FAILED = 5'd2;
   localparam logic [IDX_W-1:0] IDX_COLL_COUNT  = 5'd3;
   localparam logic [IDX_W-1:0] IDX_COLL_MIN    = 5'd4;
   localparam logic [IDX_W-1:0] IDX_COLL_MAX    = 5'd5;
   localparam logic [IDX_W-1:0] IDX_COLL_MEAN   = 5'd6;
   localparam logic [IDX_W-1:0] IDX_RTR_READS   = 5'd7;
   localparam logic [IDX_W-1:0] IDX_RTR_FWD     = 5'd8;
   localparam logic [IDX_W-1:0] IDX_RTR_BYTES   = 5'd9;
   localparam logic [IDX_W-1:0] IDX_RTR_FAILED  = 5'd10;
   localparam logic [IDX_W-1:0] IDX_RTR_COUNT   = 5'd11;
   localparam logic [IDX_W-1:0] IDX_RTR_MIN     = 5'd12;
   localparam logic [IDX_W-1:0] IDX_RTR_MAX     = 5'd13;
   localparam logic [IDX_W-1:0] IDX_RTR_MEAN    = 5'd14;
   localparam logic [IDX_W-1:0] IDX_VWR_MSGS    = 5'd15;
   localparam logic [IDX_W-1:0] IDX_VWR_BYTES   = 5'd16;
   localparam logic [IDX_W-1:0] IDX_VWR_COUNT   = 5'd17;
   localparam logic [IDX_W-1:0] IDX_VWR_MIN     = 5'd18;
   localparam logic [IDX_W-1:0] IDX_VWR_MAX     = 5'd19;
   localparam logic [IDX_W-1:0] IDX_VWR_MEAN    = 5'd20;
   localparam logic [IDX_W-1:0] IDX_TOT_EVENTS  = 5'd21;
   localparam logic [IDX_W-1:0] IDX_TOT_ERRORS  = 5'd22;
   localparam logic [IDX_W-1:0] IDX_SNAP_ID     = 5'd23;

   typedef struct packed {
      logic accept;
      logic mul;
      logic div_start;
      logic wb;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic snap_req;
      logic mean_req;
      logic div_done;
      logic out_free;
      logic emit_last;
   } dp_status_type;

endpackage

// ----- hw/rtl/els_req_if.sv -----
// ----------------------------------------------------------------------------
// els_req_if: request channel
// Valid/ready channel carrying one event, snapshot or clear transaction.
// ----------------------------------------------------------------------------
interface els_req_if import els_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic                success;
   logic [BYTE_W-1:0]   byte_count;
   logic [LAT_IN_W-1:0] latency;

   modport source (
      output valid, func, success, byte_count, latency,
      input  ready
   );

   modport sink (
      input  valid, func, success, byte_count, latency,
      output ready
   );

endinterface

// ----- hw/rtl/els_rsp_if.sv -----
// ----------------------------------------------------------------------------
// els_rsp_if: response channel
// Valid/ready channel carrying one indexed statistic per transaction.
// ----------------------------------------------------------------------------
interface els_rsp_if import els_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  stat_index;
   logic [STAT_W-1:0] stat_value;
   logic              last;

   modport source (
      output valid, stat_index, stat_value, last,
      input  ready
   );

   modport sink (
      input  valid, stat_index, stat_value, last,
      output ready
   );

endinterface

// ----- hw/rtl/event_latency_statistics_core.sv -----
// ----------------------------------------------------------------------------
// event_latency_statistics_core: event latency statistics monitor
// Counts collector, router and viewer events and keeps per-source latency
// statistics; a snapshot transaction reads out all 24 statistics.
// ----------------------------------------------------------------------------
// One request transaction is processed at a time. A clear, a failed
// collector/router event, or an event whose source sample count has
// saturated is finished in its accept cycle. An event that records a
// latency sample goes through the accept cycle, the multiply, the divider
// load, the serial divider for the running mean at one quotient bit per
// cycle, and then the write-back. A snapshot sends one response per cycle
// from the output register while the response side is ready.
// The last response of a snapshot may still wait in the output register
// while the next request is taken. Reset clears all statistics and the
// snapshot id; a clear transaction keeps the snapshot id.
module event_latency_statistics_core import els_pkg::*; #(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF,
   parameter int LATENCY_WIDTH = LATENCY_WIDTH_DEF
) (
   input logic       clock,
   input logic       reset,
   els_req_if.sink   req_chan,
   els_rsp_if.source rsp_chan
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   els_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   els_dp #(
      .COUNTER_WIDTH (COUNTER_WIDTH),
      .LATENCY_WIDTH (LATENCY_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_func       (req_chan.func),
      .req_success    (req_chan.success),
      .req_byte_count (req_chan.byte_count),
      .req_latency    (req_chan.latency),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_stat_index (rsp_chan.stat_index),
      .rsp_stat_value (rsp_chan.stat_value),
      .rsp_last       (rsp_chan.last)
   );

   a_snap_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.func == FUNC_SNAPSHOT)
      |=> !req_chan.ready)
      else $error("request taken right after a snapshot transaction");

   a_emit_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("response register overwritten before it was taken");

   a_wb_after_div: assert property (@(posedge clock) disable iff (reset)
      cmd.wb |-> status.div_done)
      else $error("mean written back before the divider finished");

   a_last_is_id: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.emit_last) |=> (rsp_chan.last && rsp_chan.valid))
      else $error("snapshot id response not flagged last");

endmodule

// ----- hw/rtl/els_div.sv -----
// ----------------------------------------------------------------------------
// els_div: serial restoring divider
// One quotient bit per cycle. The upper part of the numerator must be
// below the divisor, so the quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
module els_div import els_pkg::*; #(
   parameter int QUO_W = LATENCY_WIDTH_DEF,
   parameter int DEN_W = SAMPLE_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [DEN_W+QUO_W-1:0] num,
   input  logic [DEN_W-1:0]       den,
   output logic [QUO_W-1:0]       quo,
   output logic                   done
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[QUO_W-1]};
      fits    = trial >= {1'b0, den};
      diff    = trial - {1'b0, den};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num[DEN_W+QUO_W-1:QUO_W];
         quo_in  = num[QUO_W-1:0];
         step_in = CNT_W'(QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in  = {quo_ff[QUO_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule

// ----- hw/rtl/els_ctrl.sv -----
// ----------------------------------------------------------------------------
// els_ctrl: sequencing controller
// Accepts one transaction at a time, steps the mean update through
// multiply, divider load and divide, and paces the snapshot readout.
// ----------------------------------------------------------------------------
module els_ctrl import els_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_LOAD = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_SNAP = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               if (status.snap_req) begin
                  state_in = ST_SNAP;
               end else if (status.mean_req) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.wb   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SNAP: begin
            cmd.emit = status.out_free;
            if (status.out_free && status.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/els_dp.sv -----
// ----------------------------------------------------------------------------
// els_dp: statistics datapath
// Saturating event counters, per-source latency statistics, mean update
// (multiplier plus serial divider) and the registered response stage.
// ----------------------------------------------------------------------------
module els_dp import els_pkg::*; #(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF,
   parameter int LATENCY_WIDTH = LATENCY_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       status,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic                req_success,
   input  logic [BYTE_W-1:0]   req_byte_count,
   input  logic [LAT_IN_W-1:0] req_latency,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [IDX_W-1:0]    rsp_stat_index,
   output logic [STAT_W-1:0]   rsp_stat_value,
   output logic                rsp_last
);

   localparam int CW    = COUNTER_WIDTH;
   localparam int LW    = LATENCY_WIDTH;
   localparam int NUM_W = LW + SAMPLE_W;
   localparam int SUM_W = ((CW > BYTE_W) ? CW : BYTE_W) + 1;
   localparam int XW    = (LW > LAT_IN_W) ? LW : LAT_IN_W;

   function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                             input logic [BYTE_W-1:0] b);
      logic [SUM_W-1:0] s;
      s = SUM_W'(a) + SUM_W'(b);
      if (s > SUM_W'({CW{1'b1}})) begin
         return '1;
      end
      return s[CW-1:0];
   endfunction

   logic [CW-1:0] coll_events_ff, coll_events_in;
   logic [CW-1:0] coll_ok_ff,     coll_ok_in;
   logic [CW-1:0] coll_failed_ff, coll_failed_in;
   logic [CW-1:0] rtr_reads_ff,   rtr_reads_in;
   logic [CW-1:0] rtr_fwd_ff,     rtr_fwd_in;
   logic [CW-1:0] rtr_bytes_ff,   rtr_bytes_in;
   logic [CW-1:0] rtr_failed_ff,  rtr_failed_in;
   logic [CW-1:0] vwr_msgs_ff,    vwr_msgs_in;
   logic [CW-1:0] vwr_bytes_ff,   vwr_bytes_in;
   logic [CW-1:0] tot_events_ff,  tot_events_in;
   logic [CW-1:0] tot_errors_ff,  tot_errors_in;

   logic [SAMPLE_W-1:0] cnt_ff  [NUM_SRC];
   logic [SAMPLE_W-1:0] cnt_in  [NUM_SRC];
   logic [LW-1:0]       min_ff  [NUM_SRC];
   logic [LW-1:0]       min_in  [NUM_SRC];
   logic [LW-1:0]       max_ff  [NUM_SRC];
   logic [LW-1:0]       max_in  [NUM_SRC];
   logic [LW-1:0]       mean_ff [NUM_SRC];
   logic [LW-1:0]       mean_in [NUM_SRC];

   logic [SNAP_ID_W-1:0] snap_id_ff, snap_id_in;
   logic [IDX_W-1:0]     snap_idx_ff, snap_idx_in;

   src_type         src_ff, src_in, src_sel;
   logic [LW-1:0]   x_ff, x_in, x_sel;
   logic [NUM_W-1:0] prod_ff, prod_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [STAT_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [XW-1:0]       lat_ext;
   logic [XW-1:0]       lat_max;
   logic                rec;
   logic [NUM_W-1:0]    div_num;
   logic [SAMPLE_W-1:0] div_den;
   logic [LW-1:0]       div_quo;
   logic                div_done;
   logic [STAT_W-1:0]   stat_val;

   // request decode
   always_comb begin
      lat_ext = XW'(req_latency);
      lat_max = XW'({LW{1'b1}});
      x_sel   = (lat_ext > lat_max) ? lat_max[LW-1:0] : lat_ext[LW-1:0];
      src_sel = SRC_COLLECTOR;
      rec     = 1'b0;
      unique case (req_func)
         FUNC_COLLECTOR: begin
            src_sel = SRC_COLLECTOR;
            rec     = req_success;
         end
         FUNC_ROUTER: begin
            src_sel = SRC_ROUTER;
            rec     = req_success;
         end
         FUNC_VIEWER: begin
            src_sel = SRC_VIEWER;
            rec     = 1'b1;
         end
         default: begin
            src_sel = SRC_COLLECTOR;
            rec     = 1'b0;
         end
      endcase
      status.snap_req  = req_func == FUNC_SNAPSHOT;
      status.mean_req  = rec && (cnt_ff[src_sel] != '1);
      status.div_done  = div_done;
      status.out_free  = !rsp_valid_ff || rsp_ready;
      status.emit_last = snap_idx_ff == IDX_SNAP_ID;
   end

   // statistic select for readout
   always_comb begin
      case (snap_idx_ff)
         IDX_COLL_EVENTS: stat_val = STAT_W'(coll_events_ff);
         IDX_COLL_OK:     stat_val = STAT_W'(coll_ok_ff);
         IDX_COLL_FAILED: stat_val = STAT_W'(coll_failed_ff);
         IDX_COLL_COUNT:  stat_val = STAT_W'(cnt_ff[SRC_COLLECTOR]);
         IDX_COLL_MIN:    stat_val = STAT_W'(min_ff[SRC_COLLECTOR]);
         IDX_COLL_MAX:    stat_val = STAT_W'(max_ff[SRC_COLLECTOR]);
         IDX_COLL_MEAN:   stat_val = STAT_W'(mean_ff[SRC_COLLECTOR]);
         IDX_RTR_READS:   stat_val = STAT_W'(rtr_reads_ff);
         IDX_RTR_FWD:     stat_val = STAT_W'(rtr_fwd_ff);
         IDX_RTR_BYTES:   stat_val = STAT_W'(rtr_bytes_ff);
         IDX_RTR_FAILED:  stat_val = STAT_W'(rtr_failed_ff);
         IDX_RTR_COUNT:   stat_val = STAT_W'(cnt_ff[SRC_ROUTER]);
         IDX_RTR_MIN:     stat_val = STAT_W'(min_ff[SRC_ROUTER]);
         IDX_RTR_MAX:     stat_val = STAT_W'(max_ff[SRC_ROUTER]);
         IDX_RTR_MEAN:    stat_val = STAT_W'(mean_ff[SRC_ROUTER]);
         IDX_VWR_MSGS:    stat_val = STAT_W'(vwr_msgs_ff);
         IDX_VWR_BYTES:   stat_val = STAT_W'(vwr_bytes_ff);
         IDX_VWR_COUNT:   stat_val = STAT_W'(cnt_ff[SRC_VIEWER]);
         IDX_VWR_MIN:     stat_val = STAT_W'(min_ff[SRC_VIEWER]);
         IDX_VWR_MAX:     stat_val = STAT_W'(max_ff[SRC_VIEWER]);
         IDX_VWR_MEAN:    stat_val = STAT_W'(mean_ff[SRC_VIEWER]);
         IDX_TOT_EVENTS:  stat_val = STAT_W'(tot_events_ff);
         IDX_TOT_ERRORS:  stat_val = STAT_W'(tot_errors_ff);
         IDX_SNAP_ID:     stat_val = STAT_W'(snap_id_ff);
         default:         stat_val = '0;
      endcase
   end

   // next state
   always_comb begin
      coll_events_in = coll_events_ff;
      coll_ok_in     = coll_ok_ff;
      coll_failed_in = coll_failed_ff;
      rtr_reads_in   = rtr_reads_ff;
      rtr_fwd_in     = rtr_fwd_ff;
      rtr_bytes_in   = rtr_bytes_ff;
      rtr_failed_in  = rtr_failed_ff;
      vwr_msgs_in    = vwr_msgs_ff;
      vwr_bytes_in   = vwr_bytes_ff;
      tot_events_in  = tot_events_ff;
      tot_errors_in  = tot_errors_ff;
      cnt_in         = cnt_ff;
      min_in         = min_ff;
      max_in         = max_ff;
      mean_in        = mean_ff;
      snap_id_in     = snap_id_ff;
      snap_idx_in    = snap_idx_ff;
      src_in         = src_ff;
      x_in           = x_ff;
      prod_in        = prod_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_idx_in     = rsp_idx_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_last_in    = rsp_last_ff;

      if (cmd.accept) begin
         unique case (req_func)
            FUNC_COLLECTOR: begin
               coll_events_in = sat_add(coll_events_ff, BYTE_W'(1));
               tot_events_in  = sat_add(tot_events_ff, BYTE_W'(1));
               if (req_success) begin
                  coll_ok_in = sat_add(coll_ok_ff, BYTE_W'(1));
               end else begin
                  coll_failed_in = sat_add(coll_failed_ff, BYTE_W'(1));
                  tot_errors_in  = sat_add(tot_errors_ff, BYTE_W'(1));
               end
            end
            FUNC_ROUTER: begin
               rtr_reads_in  = sat_add(rtr_reads_ff, BYTE_W'(1));
               tot_events_in = sat_add(tot_events_ff, BYTE_W'(1));
               if (req_success) begin
                  rtr_fwd_in   = sat_add(rtr_fwd_ff, BYTE_W'(1));
                  rtr_bytes_in = sat_add(rtr_bytes_ff, req_byte_count);
               end else begin
                  rtr_failed_in = sat_add(rtr_failed_ff, BYTE_W'(1));
                  tot_errors_in = sat_add(tot_errors_ff, BYTE_W'(1));
               end
            end
            FUNC_VIEWER: begin
               vwr_msgs_in   = sat_add(vwr_msgs_ff, BYTE_W'(1));
               vwr_bytes_in  = sat_add(vwr_bytes_ff, req_byte_count);
               tot_events_in = sat_add(tot_events_ff, BYTE_W'(1));
            end
            FUNC_SNAPSHOT: begin
               snap_idx_in = '0;
            end
            FUNC_CLEAR: begin
               coll_events_in = '0;
               coll_ok_in     = '0;
               coll_failed_in = '0;
               rtr_reads_in   = '0;
               rtr_fwd_in     = '0;
               rtr_bytes_in   = '0;
               rtr_failed_in  = '0;
               vwr_msgs_in    = '0;
               vwr_bytes_in   = '0;
               tot_events_in  = '0;
               tot_errors_in  = '0;
               cnt_in         = '{default: '0};
               min_in         = '{default: '0};
               max_in         = '{default: '0};
               mean_in        = '{default: '0};
            end
            default: begin
            end
         endcase
         if (rec) begin
            src_in = src_sel;
            x_in   = x_sel;
            if (cnt_ff[src_sel] == '0) begin
               min_in[src_sel] = x_sel;
               max_in[src_sel] = x_sel;
            end else begin
               if (x_sel < min_ff[src_sel]) begin
                  min_in[src_sel] = x_sel;
               end
               if (x_sel > max_ff[src_sel]) begin
                  max_in[src_sel] = x_sel;
               end
            end
         end
      end

      if (cmd.mul) begin
         prod_in = NUM_W'(mean_ff[src_ff]) * NUM_W'(cnt_ff[src_ff]);
      end

      if (cmd.wb) begin
         mean_in[src_ff] = div_quo;
         cnt_in[src_ff]  = cnt_ff[src_ff] + 1'b1;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = snap_idx_ff;
         rsp_value_in = stat_val;
         rsp_last_in  = status.emit_last;
         snap_idx_in  = snap_idx_ff + 1'b1;
         if (status.emit_last) begin
            snap_id_in = snap_id_ff + 1'b1;
         end
      end
   end

   assign div_num = prod_ff + NUM_W'(x_ff);
   assign div_den = cnt_ff[src_ff] + 1'b1;

   els_div #(
      .QUO_W (LW),
      .DEN_W (SAMPLE_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .done  (div_done)
   );

   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      x_ff         <= x_in;
      prod_ff      <= prod_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         coll_events_ff <= '0;
         coll_ok_ff     <= '0;
         coll_failed_ff <= '0;
         rtr_reads_ff   <= '0;
         rtr_fwd_ff     <= '0;
         rtr_bytes_ff   <= '0;
         rtr_failed_ff  <= '0;
         vwr_msgs_ff    <= '0;
         vwr_bytes_ff   <= '0;
         tot_events_ff  <= '0;
         tot_errors_ff  <= '0;
         cnt_ff         <= '{default: '0};
         min_ff         <= '{default: '0};
         max_ff         <= '{default: '0};
         mean_ff        <= '{default: '0};
         snap_id_ff     <= '0;
         snap_idx_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         coll_events_ff <= coll_events_in;
         coll_ok_ff     <= coll_ok_in;
         coll_failed_ff <= coll_failed_in;
         rtr_reads_ff   <= rtr_reads_in;
         rtr_fwd_ff     <= rtr_fwd_in;
         rtr_bytes_ff   <= rtr_bytes_in;
         rtr_failed_ff  <= rtr_failed_in;
         vwr_msgs_ff    <= vwr_msgs_in;
         vwr_bytes_ff   <= vwr_bytes_in;
         tot_events_ff  <= tot_events_in;
         tot_errors_ff  <= tot_errors_in;
         cnt_ff         <= cnt_in;
         min_ff         <= min_in;
         max_ff         <= max_in;
         mean_ff        <= mean_in;
         snap_id_ff     <= snap_id_in;
         snap_idx_ff    <= snap_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_stat_index = rsp_idx_ff;
   assign rsp_stat_value = rsp_value_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
